### design/acsp_pkg.sv
package acsp_pkg;

    // Stream bytes that steer the parser.
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_S_UP   = 8'h53;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_F_LOW  = 8'h66;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_S_LOW  = 8'h73;
    localparam logic [7:0] CH_U      = 8'h75;

    // Parameter values with a meaning for SGR and erase display.
    localparam logic [7:0] SGR_RESET      = 8'd0;
    localparam logic [7:0] SGR_INVERSE    = 8'd7;
    localparam logic [7:0] SGR_NO_INVERSE = 8'd27;
    localparam logic [7:0] SGR_FG_FIRST   = 8'd30;
    localparam logic [7:0] SGR_FG_LAST    = 8'd37;
    localparam logic [7:0] SGR_BG_FIRST   = 8'd40;
    localparam logic [7:0] SGR_BG_LAST    = 8'd47;
    localparam logic [7:0] ED_WHOLE       = 8'd2;
    localparam logic [7:0] PARAM_MAX      = 8'd255;

    localparam int COLOR_W = 24;

    localparam logic [COLOR_W-1:0] DEFAULT_FG_RESET = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] DEFAULT_BG_RESET = 24'h000000;

    // Configuration register addresses.
    localparam int CFG_ADDR_W = 3;
    localparam logic CFG_SEL_FG = 1'b0;
    localparam logic CFG_SEL_BG = 1'b1;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_DRAW    = 3'd1,
        ACT_CLEAR   = 3'd2,
        ACT_SAVE    = 3'd3,
        ACT_RESTORE = 3'd4
    } t_action;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_ESC   = 6'b000010,
        PH_START = 6'b000100,
        PH_FIRST = 6'b001000,
        PH_SEP   = 6'b010000,
        PH_LATER = 6'b100000
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [7:0]           param_value;
        logic                 param_seen;
        logic [COLOR_W-1:0]   fg;
        logic [COLOR_W-1:0]   bg;
        logic                 inverse;
    } t_parse_state;

    typedef struct packed {
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } t_defaults;

    typedef struct packed {
        t_action    action;
        logic [7:0] glyph;
    } t_step_result;

    // Eight-color palette used by SGR 30..37 and 40..47.
    function automatic logic [COLOR_W-1:0] palette_color(input logic [2:0] idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            3'd0:    c = 24'h000000;
            3'd1:    c = 24'hAA0000;
            3'd2:    c = 24'h00AA00;
            3'd3:    c = 24'h808000;
            3'd4:    c = 24'h0000AA;
            3'd5:    c = 24'hAA00AA;
            3'd6:    c = 24'h00AAAA;
            default: c = 24'hAAAAAA;
        endcase
        return c;
    endfunction

endpackage

### design/ansi_csi_sgr_parser_unit.sv
// ANSI escape parser for a byte stream of terminal output. Each accepted byte
// produces exactly one result carrying an action (none, draw, clear screen,
// save cursor, restore cursor), the byte to draw, and the foreground and
// background colors in force after that byte. The parser recognizes
// ESC [ <digits> [; <digits>...] <command>, keeps only the first numeric
// parameter (saturating at 255), and acts on SGR (m), erase display (J 2),
// save (s) and restore (u). The byte flagged by tlast closes a write; any
// sequence still open at that point is abandoned. The block takes one byte
// per clock cycle while the result register is free, and holds off the
// input when the master side stalls: a byte waits in the input register, the
// parser's next state and the result are computed from it combinationally,
// and the result register and the parser state are loaded when that byte
// advances, after which the result is offered on the master side. The
// default colors restored by SGR 0 are written over the APB port at
// addresses 0x0 (foreground) and 0x4 (background); the user must write them
// only while the stream is idle, and the block itself does not enforce this.
module ansi_csi_sgr_parser_unit
    import acsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] text_byte
    input  logic                  i_s_tlast,   // end_of_write

    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [55:0]           o_m_tdata,   // [7:0] glyph_byte, [31:8] foreground,
                                               // [55:32] background
    output logic [2:0]            o_m_tuser,   // [2:0] action

    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    output logic [31:0]           o_prdata,
    output logic                  o_pready
);

    t_defaults    defaults;
    t_parse_state r_state;
    t_parse_state n_state;
    t_step_result step_res;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_eow;

    logic         r_out_valid;
    t_action      r_out_action;
    logic [7:0]   r_out_glyph;
    logic [COLOR_W-1:0] r_out_fg;
    logic [COLOR_W-1:0] r_out_bg;

    logic         out_free;
    logic         advance;
    logic         in_take;

    acsp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready),
        .o_defaults (defaults)
    );

    acsp_step u_step (
        .i_state    (r_state),
        .i_byte     (r_in_byte),
        .i_eow      (r_in_eow),
        .i_defaults (defaults),
        .o_state    (n_state),
        .o_result   (step_res)
    );

    // The result register is free when empty or being drained this cycle.
    // The buffered byte is processed, and the parser state committed, only
    // when its result has a place to go.
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state.phase       <= PH_IDLE;
            r_state.param_value <= 8'd0;
            r_state.param_seen  <= 1'b0;
            r_state.fg          <= DEFAULT_FG_RESET;
            r_state.bg          <= DEFAULT_BG_RESET;
            r_state.inverse     <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_tdata;
            r_in_eow  <= i_s_tlast;
        end
        if (advance) begin
            r_out_action <= step_res.action;
            r_out_glyph  <= step_res.glyph;
            r_out_fg     <= n_state.fg;
            r_out_bg     <= n_state.bg;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_bg, r_out_fg, r_out_glyph};
    assign o_m_tuser  = r_out_action;

endmodule

### design/acsp_cfg_regs.sv
module acsp_cfg_regs
    import acsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    output logic [31:0]           o_prdata,
    output logic                  o_pready,
    output t_defaults             o_defaults
);

    logic [COLOR_W-1:0] r_def_fg;
    logic [COLOR_W-1:0] r_def_bg;
    logic               wr_en;
    logic               sel;

    // Registers sit four bytes apart, so bit 2 picks one of the two.
    assign sel   = i_paddr[2];
    assign wr_en = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_fg <= DEFAULT_FG_RESET;
            r_def_bg <= DEFAULT_BG_RESET;
        end else if (wr_en) begin
            if (sel == CFG_SEL_FG) begin
                r_def_fg <= i_pwdata[COLOR_W-1:0];
            end else begin
                r_def_bg <= i_pwdata[COLOR_W-1:0];
            end
        end
    end

    always_comb begin
        if (sel == CFG_SEL_FG) begin
            o_prdata = {{(32-COLOR_W){1'b0}}, r_def_fg};
        end else begin
            o_prdata = {{(32-COLOR_W){1'b0}}, r_def_bg};
        end
    end

    assign o_pready      = 1'b1;
    assign o_defaults.fg = r_def_fg;
    assign o_defaults.bg = r_def_bg;

endmodule

### design/acsp_step.sv
module acsp_step
    import acsp_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_byte,
    input  logic         i_eow,
    input  t_defaults    i_defaults,
    output t_parse_state o_state,
    output t_step_result o_result
);

    logic               is_digit;
    logic               is_cmd;
    logic [3:0]         digit;
    logic [11:0]        acc;
    logic               run_cmd;
    logic [7:0]         param;
    logic [7:0]         pal_off;
    t_phase             n_phase;
    logic [7:0]         n_param_value;
    logic               n_param_seen;
    logic [COLOR_W-1:0] n_fg;
    logic [COLOR_W-1:0] n_bg;
    logic               n_inverse;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = i_byte[3:0];
    assign acc      = 12'(i_state.param_value) * 12'd10 + 12'(digit);

    // The end of a write abandons any open sequence.
    assign o_state = {(i_eow ? PH_IDLE : n_phase), n_param_value, n_param_seen,
                      n_fg, n_bg, n_inverse};

    always_comb begin
        case (i_byte) inside
            [CH_A:CH_H], CH_J, CH_K, CH_S_UP, CH_T, CH_F_LOW, CH_M, CH_S_LOW, CH_U,
            CH_NUL:  is_cmd = 1'b1;
            default: is_cmd = 1'b0;
        endcase
    end

    // Parse phase, parameter capture and the draw, clear, save and restore actions.
    always_comb begin
        n_phase         = i_state.phase;
        n_param_value   = i_state.param_value;
        n_param_seen    = i_state.param_seen;
        o_result.action = ACT_NONE;
        o_result.glyph  = 8'd0;
        run_cmd         = 1'b0;
        param           = i_state.param_seen ? i_state.param_value : 8'd0;

        unique case (i_state.phase)
            PH_IDLE, PH_ESC: begin
                if (i_state.phase == PH_ESC && i_byte == CH_LBRACK) begin
                    n_phase = PH_START;
                end else if (i_byte == CH_ESC) begin
                    n_phase = PH_ESC;
                end else begin
                    // A stray ESC is dropped and this byte is plain text.
                    n_phase         = PH_IDLE;
                    o_result.action = ACT_DRAW;
                    o_result.glyph  = i_byte;
                end
            end
            PH_START: begin
                n_param_value = 8'd0;
                n_param_seen  = 1'b0;
                param         = 8'd0;
                if (is_digit) begin
                    n_param_value = 8'(digit);
                    n_param_seen  = 1'b1;
                    n_phase       = PH_FIRST;
                end else begin
                    run_cmd = is_cmd;
                    n_phase = PH_IDLE;
                end
            end
            PH_FIRST, PH_LATER: begin
                if (i_byte == CH_SEMI) begin
                    n_phase = PH_SEP;
                end else if (is_digit) begin
                    if (i_state.phase == PH_FIRST) begin
                        n_param_value = (acc > 12'(PARAM_MAX)) ? PARAM_MAX : acc[7:0];
                    end
                end else begin
                    run_cmd = is_cmd;
                    n_phase = PH_IDLE;
                end
            end
            PH_SEP: begin
                n_phase = is_digit ? PH_LATER : PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (run_cmd) begin
            if (i_byte == CH_J && param == ED_WHOLE) begin
                o_result.action = ACT_CLEAR;
            end else if (i_byte == CH_S_LOW) begin
                o_result.action = ACT_SAVE;
            end else if (i_byte == CH_U) begin
                o_result.action = ACT_RESTORE;
            end
        end
    end

    // Colour changes from SGR.
    always_comb begin
        n_fg      = i_state.fg;
        n_bg      = i_state.bg;
        n_inverse = i_state.inverse;
        pal_off   = 8'd0;

        if (run_cmd && i_byte == CH_M) begin
            if (param == SGR_RESET) begin
                n_fg = i_defaults.fg;
                n_bg = i_defaults.bg;
            end else if (param == SGR_INVERSE) begin
                if (!i_state.inverse) begin
                    n_fg      = i_state.bg;
                    n_bg      = i_state.fg;
                    n_inverse = 1'b1;
                end
            end else if (param == SGR_NO_INVERSE) begin
                if (i_state.inverse) begin
                    n_fg      = i_state.bg;
                    n_bg      = i_state.fg;
                    n_inverse = 1'b0;
                end
            end else if (param >= SGR_FG_FIRST && param <= SGR_FG_LAST) begin
                pal_off = param - SGR_FG_FIRST;
                n_fg    = palette_color(pal_off[2:0]);
            end else if (param >= SGR_BG_FIRST && param <= SGR_BG_LAST) begin
                pal_off = param - SGR_BG_FIRST;
                n_bg    = palette_color(pal_off[2:0]);
            end
        end
    end

endmodule
